// ----- rtl/tmlc_pkg.sv -----
// Shared types, widths and reset constants for the trimmed-mean level classifier.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tmlc_pkg;

  // Default window length and sample width, handed to the top-level parameters.
  localparam int unsigned DEF_WINDOW_LEN  = 10;
  localparam int unsigned DEF_SAMPLE_BITS = 12;

  // Fixed widths of the accumulator and the result fields.
  localparam int unsigned SUM_BITS      = 16;
  localparam int unsigned AVG_BITS      = 12;
  localparam int unsigned LEVEL_BITS    = 3;
  localparam int unsigned OUT_DATA_BITS = 16;

  // Threshold register file.
  localparam int unsigned THRESH_BITS = 12;
  localparam int unsigned NUM_THRESH  = 5;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned REG_IDX_BITS  = 3;

  // Depth of the queue between the accumulator and the divider.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [NUM_THRESH-1:0][THRESH_BITS-1:0] threshold_set_t;

  // Reset values, threshold_0 in the lowest slot.
  localparam threshold_set_t THRESH_RESET = {
    12'd2337, 12'd2271, 12'd2175, 12'd2125, 12'd2063
  };

  // Register indexes as seen on the configuration port (address / 4).
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_THRESHOLD_0 = 3'd0,
    REG_THRESHOLD_1 = 3'd1,
    REG_THRESHOLD_2 = 3'd2,
    REG_THRESHOLD_3 = 3'd3,
    REG_THRESHOLD_4 = 3'd4
  } reg_index_t;

  // One finished window travelling from the accumulator to the queue.
  typedef struct packed {
    logic                valid;
    logic [SUM_BITS-1:0] trimmed;
  } trim_item_t;

endpackage

`default_nettype wire

// ----- rtl/trimmed_mean_level_classifier_top.sv -----
// Top level of the trimmed-mean level classifier.
// Instantiates tmlc_regs, tmlc_front, tmlc_queue and tmlc_back; uses tmlc_pkg.
//
// Usage:
//   Samples enter on the s_axis channel, one per transfer, in the low SAMPLE_BITS
//   of s_axis_tdata. Every WINDOW_LEN samples form a window. The largest and the
//   smallest sample are removed, the rest is divided by WINDOW_LEN-2 with
//   truncation, and one result leaves on the m_axis channel: the average and a
//   charge level 0..5 from compares against the five threshold registers.
//   Thresholds are read and written through the APB-style port at byte
//   addresses 0, 4, 8, 12 and 16; pready is always high.
//
//   Throughput: one sample per cycle while the queue is not full. The accumulators
//   take a sample every such cycle; the divider is a constant-reciprocal multiply,
//   one product per cycle while the output is not stalled. A window's trimmed sum
//   passes through the queue, product register and output register to the result.
//
//   Reset (rst, synchronous) restores the threshold reset values, empties the
//   queue and the pipeline, and restarts the window.
//   When the receiver stalls, the result holds in the output register; three more
//   window results can wait in the product stage and the two-entry queue, and
//   only then does s_axis_tready fall.
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_level_classifier_top #(
  parameter int unsigned WINDOW_LEN  = tmlc_pkg::DEF_WINDOW_LEN,
  parameter int unsigned SAMPLE_BITS = tmlc_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Sample stream.
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // [0+:SAMPLE_BITS] sample
  // Result stream.
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  output logic      [tmlc_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,  // [11:0] average, [14:12] level
  // Configuration port.
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [tmlc_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  wire logic [tmlc_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic      [tmlc_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                        pready
);
  import tmlc_pkg::*;

  threshold_set_t        thresholds;
  trim_item_t            push;
  logic                  queue_full;
  logic                  queue_valid;
  logic                  queue_ready;
  logic [SUM_BITS-1:0]   queue_data;
  logic [AVG_BITS-1:0]   average;
  logic [LEVEL_BITS-1:0] level;

  tmlc_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .thresholds (thresholds)
  );

  tmlc_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .queue_full (queue_full),
    .push       (push)
  );

  tmlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .pop_valid (queue_valid),
    .pop_ready (queue_ready),
    .pop_data  (queue_data)
  );

  tmlc_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (queue_valid),
    .in_ready   (queue_ready),
    .trimmed    (queue_data),
    .thresholds (thresholds),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .average    (average),
    .level      (level)
  );

  // Pack the result fields, padding bit on top.
  assign m_axis_tdata = OUT_DATA_BITS'({level, average});

endmodule

`default_nettype wire

// ----- rtl/tmlc_regs.sv -----
// Threshold register file behind the APB-style configuration port.
// Depends on tmlc_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module tmlc_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tmlc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [tmlc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [tmlc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  output tmlc_pkg::threshold_set_t                thresholds
);
  import tmlc_pkg::*;

  reg_index_t     reg_idx;
  logic           wr_en;
  threshold_set_t thresholds_next;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[REG_IDX_BITS+1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Write decode; an index past the last register is ignored.
  always_comb begin
    thresholds_next = thresholds;
    if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD_0: thresholds_next[0] = pwdata[THRESH_BITS-1:0];
        REG_THRESHOLD_1: thresholds_next[1] = pwdata[THRESH_BITS-1:0];
        REG_THRESHOLD_2: thresholds_next[2] = pwdata[THRESH_BITS-1:0];
        REG_THRESHOLD_3: thresholds_next[3] = pwdata[THRESH_BITS-1:0];
        REG_THRESHOLD_4: thresholds_next[4] = pwdata[THRESH_BITS-1:0];
        default:         thresholds_next = thresholds;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds <= THRESH_RESET;
    end else begin
      thresholds <= thresholds_next;
    end
  end

  // Read mux; unused addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD_0: prdata = APB_DATA_BITS'(thresholds[0]);
      REG_THRESHOLD_1: prdata = APB_DATA_BITS'(thresholds[1]);
      REG_THRESHOLD_2: prdata = APB_DATA_BITS'(thresholds[2]);
      REG_THRESHOLD_3: prdata = APB_DATA_BITS'(thresholds[3]);
      REG_THRESHOLD_4: prdata = APB_DATA_BITS'(thresholds[4]);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tmlc_front.sv -----
// Front end: accepts samples and keeps the running sum, maximum and minimum.
// On the last sample of a window it hands the trimmed sum on. Uses tmlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmlc_front #(
  parameter int unsigned WINDOW_LEN  = tmlc_pkg::DEF_WINDOW_LEN,
  parameter int unsigned SAMPLE_BITS = tmlc_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   queue_full,
  output tmlc_pkg::trim_item_t        push
);
  import tmlc_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(WINDOW_LEN);

  logic [CNT_BITS-1:0]    sample_count;
  logic [SUM_BITS-1:0]    running_sum;
  logic [SAMPLE_BITS-1:0] running_max;
  logic [SAMPLE_BITS-1:0] running_min;

  logic [SUM_BITS-1:0]    sum_next;
  logic [SAMPLE_BITS-1:0] max_next;
  logic [SAMPLE_BITS-1:0] min_next;
  logic                   accept;
  logic                   window_end;

  assign in_ready   = !queue_full;
  assign accept     = in_valid && in_ready;
  assign window_end = (sample_count == CNT_BITS'(WINDOW_LEN - 1));

  // Accumulator values including the sample now on the input.
  assign sum_next = running_sum + SUM_BITS'(sample);
  assign max_next = (sample > running_max) ? sample : running_max;
  assign min_next = (sample < running_min) ? sample : running_min;

  // Trimmed sum wraps modulo the accumulator width, like the sum itself.
  assign push.valid   = accept && window_end;
  assign push.trimmed = sum_next - SUM_BITS'(min_next) - SUM_BITS'(max_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_sum  <= '0;
      running_max  <= '0;
      running_min  <= '1;
    end else if (accept) begin
      if (window_end) begin
        sample_count <= '0;
        running_sum  <= '0;
        running_max  <= '0;
        running_min  <= '1;
      end else begin
        sample_count <= sample_count + 1'b1;
        running_sum  <= sum_next;
        running_max  <= max_next;
        running_min  <= min_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmlc_queue.sv -----
// Small FIFO of trimmed window sums between the front end and the divider.
// Uses tmlc_pkg for the item type and widths.
`timescale 1ns / 1ps
`default_nettype none

module tmlc_queue #(
  parameter int unsigned DEPTH = tmlc_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tmlc_pkg::trim_item_t          push,
  output logic                               full,
  output logic                               pop_valid,
  input  wire logic                          pop_ready,
  output logic [tmlc_pkg::SUM_BITS-1:0]      pop_data
);
  import tmlc_pkg::*;

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [SUM_BITS-1:0] mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.trimmed;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmlc_back.sv -----
// Back end: divides the trimmed sum by WINDOW_LEN-2 through a reciprocal
// multiply, then classifies the average into a level. Uses tmlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmlc_back #(
  parameter int unsigned WINDOW_LEN = tmlc_pkg::DEF_WINDOW_LEN
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [tmlc_pkg::SUM_BITS-1:0]     trimmed,
  input  wire tmlc_pkg::threshold_set_t          thresholds,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [tmlc_pkg::AVG_BITS-1:0]     average,
  output logic      [tmlc_pkg::LEVEL_BITS-1:0]   level
);
  import tmlc_pkg::*;

  // floor(x / DIV) == (x * RECIP) >> SHIFT for every SUM_BITS-wide x.
  localparam int unsigned     DIV       = WINDOW_LEN - 2;
  localparam int unsigned     SHIFT     = SUM_BITS + $clog2(DIV);
  localparam int unsigned     PROD_BITS = SHIFT + SUM_BITS;
  localparam longint unsigned RECIP     = ((64'd1 << SHIFT) + DIV - 1) / DIV;

  logic                  prod_valid;
  logic [PROD_BITS-1:0]  prod;
  logic                  prod_ready;
  logic [AVG_BITS-1:0]   avg_calc;
  logic [LEVEL_BITS-1:0] level_calc;

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod <= PROD_BITS'(trimmed) * PROD_BITS'(RECIP);
    end
  end

  // Quotient masked to the result width, then compared from the top down.
  assign avg_calc = prod[SHIFT +: AVG_BITS];

  always_comb begin
    priority if (avg_calc > thresholds[4]) begin
      level_calc = LEVEL_BITS'(5);
    end else if (avg_calc > thresholds[3]) begin
      level_calc = LEVEL_BITS'(4);
    end else if (avg_calc > thresholds[2]) begin
      level_calc = LEVEL_BITS'(3);
    end else if (avg_calc > thresholds[1]) begin
      level_calc = LEVEL_BITS'(2);
    end else if (avg_calc > thresholds[0]) begin
      level_calc = LEVEL_BITS'(1);
    end else begin
      level_calc = LEVEL_BITS'(0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      average <= avg_calc;
      level   <= level_calc;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmlc_checker.sv -----
// Port-level checks for the trimmed-mean level classifier, bound to the top.
// Depends on tmlc_pkg and on the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module tmlc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [tmlc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input wire logic                               pready
);
  import tmlc_pkg::*;

  // Reset empties the whole result path.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Levels stay in range and the padding bit stays clear.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[14:12] <= 3'd5) && !m_axis_tdata[15])
    else $error("level out of range");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind trimmed_mean_level_classifier_top tmlc_checker u_tmlc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

`default_nettype wire
